### hdl/bsot_pkg.sv
// ----------------------------------------------------------------------------
// bsot_pkg
// shared widths, function codes, stage types and coordinate unpacking for
// the box / sphere overlap test pipeline
// ----------------------------------------------------------------------------
package bsot_pkg;

    localparam int COORD_BITS = 16;
    localparam int AXES       = 3;
    localparam int FIELD_W    = 48;
    localparam int FUNC_W     = 2;
    localparam int RAD_W      = 15;
    localparam int RSUM_W     = RAD_W + 1;
    localparam int RSQ_W      = 2 * RSUM_W;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int SUM_W      = SQ_W + 2;
    localparam int CMP_W      = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;
    localparam int EXT_W      = FIELD_W + AXES * COORD_BITS;

    localparam logic [FUNC_W-1:0] FUNC_BOX_BOX = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SPH_BOX = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BOX_SPH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPH_SPH = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic [SQ_W-1:0]              t_sq;
    typedef logic [RSUM_W-1:0]            t_rad;
    typedef logic [RSQ_W-1:0]             t_rsq;

    // after selection and compares
    typedef struct packed {
        logic                  box_box;
        logic                  sph_sph;
        logic [AXES-1:0]       bb_fail;
        t_coord [AXES-1:0]     p;
        t_coord [AXES-1:0]     other;
        t_coord [AXES-1:0]     hi;
        logic [AXES-1:0]       lt_lo;
        logic [AXES-1:0]       gt_hi;
        logic [AXES-1:0]       lo_gt_hi;
        t_rad                  rad;
    } t_s1;

    // after clamp and difference
    typedef struct packed {
        logic                  box_box;
        logic                  box_miss;
        t_diff [AXES-1:0]      d;
        t_rad                  rad;
    } t_s2;

    // after squaring
    typedef struct packed {
        logic                  box_box;
        logic                  box_miss;
        t_sq [AXES-1:0]        sq;
        t_rsq                  rsq;
    } t_s3;

    // signed coordinate of one axis; bits past the field read as zero
    function automatic t_coord coord_of(input logic [FIELD_W-1:0] pv,
                                        input int unsigned axis);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(pv);
        return t_coord'(ext[axis*COORD_BITS +: COORD_BITS]);
    endfunction

endpackage

### hdl/bsot_prep.sv
// ----------------------------------------------------------------------------
// bsot_prep
// two register stages: shape selection with interval compares, then clamp
// of the sphere centre and per-axis difference
// ----------------------------------------------------------------------------
module bsot_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bsot_pkg::FUNC_W-1:0]         i_func,
    input  logic [bsot_pkg::FIELD_W-1:0]        i_first_low,
    input  logic [bsot_pkg::FIELD_W-1:0]        i_first_high,
    input  logic [bsot_pkg::RAD_W-1:0]          i_first_radius,
    input  logic [bsot_pkg::FIELD_W-1:0]        i_second_low,
    input  logic [bsot_pkg::FIELD_W-1:0]        i_second_high,
    input  logic [bsot_pkg::RAD_W-1:0]          i_second_radius,
    output logic                                o_valid,
    input  logic                                i_ready,
    output bsot_pkg::t_s2                       o_s2
);

    logic                            en1;
    logic                            en2;
    logic                            r_v1;
    logic                            r_v2;
    bsot_pkg::t_s1                   n_s1;
    bsot_pkg::t_s1                   r_s1;
    bsot_pkg::t_s2                   n_s2;
    bsot_pkg::t_s2                   r_s2;
    logic [bsot_pkg::FIELD_W-1:0]    cen;
    logic [bsot_pkg::FIELD_W-1:0]    blo;
    logic [bsot_pkg::FIELD_W-1:0]    bhi;
    bsot_pkg::t_coord                lo   [bsot_pkg::AXES];
    bsot_pkg::t_coord                q    [bsot_pkg::AXES];

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_s2    = r_s2;

    always_comb begin
        n_s1.box_box = (i_func == bsot_pkg::FUNC_BOX_BOX);
        n_s1.sph_sph = (i_func == bsot_pkg::FUNC_SPH_SPH);
        cen = (i_func == bsot_pkg::FUNC_BOX_SPH) ? i_second_low : i_first_low;
        blo = (i_func == bsot_pkg::FUNC_SPH_BOX) ? i_second_low : i_first_low;
        bhi = (i_func == bsot_pkg::FUNC_SPH_BOX) ? i_second_high : i_first_high;
        unique case (i_func)
            bsot_pkg::FUNC_SPH_SPH: begin
                n_s1.rad = bsot_pkg::RSUM_W'(i_first_radius)
                         + bsot_pkg::RSUM_W'(i_second_radius);
            end
            bsot_pkg::FUNC_SPH_BOX: n_s1.rad = bsot_pkg::RSUM_W'(i_first_radius);
            bsot_pkg::FUNC_BOX_SPH: n_s1.rad = bsot_pkg::RSUM_W'(i_second_radius);
            default:                n_s1.rad = '0;
        endcase
        for (int a = 0; a < bsot_pkg::AXES; a++) begin
            lo[a]        = bsot_pkg::coord_of(blo, a);
            n_s1.p[a]    = bsot_pkg::coord_of(cen, a);
            n_s1.hi[a]   = bsot_pkg::coord_of(bhi, a);
            n_s1.other[a] = n_s1.sph_sph ? bsot_pkg::coord_of(i_second_low, a) : lo[a];
            n_s1.lt_lo[a]    = $signed(n_s1.p[a]) < $signed(lo[a]);
            n_s1.gt_hi[a]    = $signed(n_s1.p[a]) > $signed(n_s1.hi[a]);
            n_s1.lo_gt_hi[a] = $signed(lo[a]) > $signed(n_s1.hi[a]);
            n_s1.bb_fail[a] =
                ($signed(bsot_pkg::coord_of(i_first_high, a))
                    < $signed(bsot_pkg::coord_of(i_second_low, a)))
                || ($signed(bsot_pkg::coord_of(i_first_low, a))
                    > $signed(bsot_pkg::coord_of(i_second_high, a)));
        end
    end

    always_comb begin
        n_s2.box_box  = r_s1.box_box;
        n_s2.box_miss = |r_s1.bb_fail;
        n_s2.rad      = r_s1.rad;
        for (int a = 0; a < bsot_pkg::AXES; a++) begin
            // clamp to min first, then to max
            if (r_s1.sph_sph) begin
                q[a] = r_s1.other[a];
            end else if (r_s1.lt_lo[a]) begin
                q[a] = r_s1.lo_gt_hi[a] ? r_s1.hi[a] : r_s1.other[a];
            end else begin
                q[a] = r_s1.gt_hi[a] ? r_s1.hi[a] : r_s1.p[a];
            end
            n_s2.d[a] = bsot_pkg::t_diff'(bsot_pkg::DIFF_W'($signed(r_s1.p[a]))
                                        - bsot_pkg::DIFF_W'($signed(q[a])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
    end

endmodule

### hdl/bsot_square.sv
// ----------------------------------------------------------------------------
// bsot_square
// one register stage squaring the three axis differences and the radius
// ----------------------------------------------------------------------------
module bsot_square (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bsot_pkg::t_s2    i_s2,
    output logic             o_valid,
    input  logic             i_ready,
    output bsot_pkg::t_s3    o_s3
);

    logic                                en;
    logic                                r_v;
    bsot_pkg::t_s3                       n_s3;
    bsot_pkg::t_s3                       r_s3;
    logic signed [bsot_pkg::PROD_W-1:0]  prod [bsot_pkg::AXES];

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_s3    = r_s3;

    always_comb begin
        n_s3.box_box  = i_s2.box_box;
        n_s3.box_miss = i_s2.box_miss;
        n_s3.rsq      = bsot_pkg::RSQ_W'(i_s2.rad) * bsot_pkg::RSQ_W'(i_s2.rad);
        for (int a = 0; a < bsot_pkg::AXES; a++) begin
            prod[a]      = $signed(i_s2.d[a]) * $signed(i_s2.d[a]);
            n_s3.sq[a]   = prod[a][bsot_pkg::SQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3 <= n_s3;
        end
    end

endmodule

### hdl/bsot_reduce.sv
// ----------------------------------------------------------------------------
// bsot_reduce
// output stage: sum of squares against squared radius, or box-box flag
// ----------------------------------------------------------------------------
module bsot_reduce (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bsot_pkg::t_s3    i_s3,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_colliding
);

    logic                              en;
    logic                              r_v;
    logic                              r_colliding;
    logic                              n_colliding;
    logic [bsot_pkg::SUM_W-1:0]        sum;

    assign en          = !r_v || i_ready;
    assign o_ready     = en;
    assign o_valid     = r_v;
    assign o_colliding = r_colliding;

    always_comb begin
        sum = bsot_pkg::SUM_W'(i_s3.sq[0]) + bsot_pkg::SUM_W'(i_s3.sq[1])
            + bsot_pkg::SUM_W'(i_s3.sq[2]);
        if (i_s3.box_box) begin
            n_colliding = !i_s3.box_miss;
        end else begin
            n_colliding = bsot_pkg::CMP_W'(sum) <= bsot_pkg::CMP_W'(i_s3.rsq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_colliding <= n_colliding;
        end
    end

endmodule

### hdl/box_sphere_overlap_test.sv
// ----------------------------------------------------------------------------
// box_sphere_overlap_test
// overlap flag for a pair of shapes, each an axis-aligned box or a sphere
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready with the two shapes; i_func bit 0 marks
// the first shape as a sphere, bit 1 the second; coordinates are packed
// x, y, z signed q8.8 with x lowest, radii unsigned q7.8
// output channel: o_valid / i_ready with o_colliding, one result per item,
// in order; touching counts as overlap
// pipeline: four register stages (select and compare, clamp and difference,
// square, sum and compare) between the accepting edge and o_valid
// throughput: one item per cycle while i_ready holds high
// stall: each stage holds while full and blocked, bubbles close up, so up
// to four items wait inside when i_ready is low; o_ready falls only when
// every stage is full
// reset: synchronous active low, empties the pipeline
// ----------------------------------------------------------------------------
module box_sphere_overlap_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bsot_pkg::FUNC_W-1:0]     i_func,
    input  logic [bsot_pkg::FIELD_W-1:0]    i_first_low,
    input  logic [bsot_pkg::FIELD_W-1:0]    i_first_high,
    input  logic [bsot_pkg::RAD_W-1:0]      i_first_radius,
    input  logic [bsot_pkg::FIELD_W-1:0]    i_second_low,
    input  logic [bsot_pkg::FIELD_W-1:0]    i_second_high,
    input  logic [bsot_pkg::RAD_W-1:0]      i_second_radius,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_colliding
);

    logic             prep_valid;
    logic             sq_ready;
    bsot_pkg::t_s2    prep_s2;
    logic             sq_valid;
    logic             red_ready;
    bsot_pkg::t_s3    sq_s3;

    bsot_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_first_low     (i_first_low),
        .i_first_high    (i_first_high),
        .i_first_radius  (i_first_radius),
        .i_second_low    (i_second_low),
        .i_second_high   (i_second_high),
        .i_second_radius (i_second_radius),
        .o_valid         (prep_valid),
        .i_ready         (sq_ready),
        .o_s2            (prep_s2)
    );

    bsot_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .o_ready (sq_ready),
        .i_s2    (prep_s2),
        .o_valid (sq_valid),
        .i_ready (red_ready),
        .o_s3    (sq_s3)
    );

    bsot_reduce u_reduce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sq_valid),
        .o_ready     (red_ready),
        .i_s3        (sq_s3),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_colliding (o_colliding)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output stage");

    a_ready_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |-> o_ready)
        else $error("input stalled while output drains");

    a_inner_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_valid && !red_ready) |-> (o_valid && !i_ready))
        else $error("square stage blocked without output stall");

endmodule
